[rtl/msp_pkg.sv]
package msp_pkg;

  localparam int MaxSize = 4;
  localparam int DataW = 32;
  localparam int IdxW = 2;
  localparam logic [2:0] SizeReset = 3'd4;

  // Codes carried on result_kind.
  localparam logic KindSum = 1'b0;
  localparam logic KindProd = 1'b1;

endpackage

[rtl/matrix_sum_product.sv]
// Square matrix sum and product of n by n signed 32-bit matrices, with n
// taken from the size register (0 acts as 1, values above MAX_SIZE act as
// MAX_SIZE); a size write restarts the load. Each element is one input
// transfer, A in row-major order, then B, and every B element puts its sum
// element in the output register. After the last B element the input
// stalls while a chain of MAX_SIZE multiply-accumulate cells, each holding
// one column of B, builds the product one row at a time: the row of A is
// fed into the chain, the chain drains, and the row is emitted; output
// stalls hold the emit and lengthen the product.
module matrix_sum_product #(
  parameter int MAX_SIZE = msp_pkg::MaxSize
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [31:0]        element_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        result_value,
  output logic                      result_kind,
  output logic [msp_pkg::IdxW-1:0]  result_row,
  output logic [msp_pkg::IdxW-1:0]  result_col,
  output logic                      last_result
);

  localparam int Depth = MAX_SIZE * MAX_SIZE;
  localparam int IW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PW = $clog2(2 * Depth + 1);
  localparam int SW = $clog2(MAX_SIZE + 1);
  localparam int KW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_FEED  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state;
  logic [2:0] size_reg;
  logic [SW-1:0] n, n_last;
  logic [PW-1:0] pos, nn, p, a_addr;
  logic [31:0] a_mem [Depth];
  logic [SW-1:0] i, j, k;
  logic feed_valid;
  logic [31:0] feed_data;
  logic [KW-1:0] feed_k;
  logic [MAX_SIZE:0] chain_valid;
  logic [31:0] chain_data [MAX_SIZE+1];
  logic [KW-1:0] chain_k [MAX_SIZE+1];
  logic [31:0] cell_acc [MAX_SIZE];
  logic chain_busy, clear;
  logic in_fire, out_fire, cfg_fire;
  logic load_a, load_b, emit_fire, row_done;
  logic [SW-1:0] prow, pcol;

  always_comb begin
    if (size_reg == 3'd0) begin
      n = SW'(1);
    end else if (32'(size_reg) > MAX_SIZE) begin
      n = SW'(MAX_SIZE);
    end else begin
      n = SW'(size_reg);
    end
  end

  assign n_last = n - SW'(1);
  assign nn = PW'(n) * PW'(n);
  assign p = pos - nn;
  assign a_addr = PW'(i) * PW'(n) + PW'(k);

  assign in_fire = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign cfg_fire = cfg_valid && cfg_ready;
  // A pending size write holds the input off so that it lands between items.
  assign in_stall = (state != ST_LOAD) || cfg_valid || (out_valid && out_stall);
  assign cfg_ready = (state == ST_LOAD) && !out_valid;
  assign load_a = in_fire && (pos < nn);
  assign load_b = in_fire && !(pos < nn);
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_fire);
  assign row_done = emit_fire && (j == n_last);
  assign clear = (state == ST_LOAD) || row_done;
  assign chain_busy = |chain_valid;

  // Row/column of p found by repeated subtraction of n (at most MAX_SIZE steps).
  always_comb begin
    logic [PW-1:0] rem;
    rem = p;
    prow = '0;
    for (int r = 0; r < MAX_SIZE; r++) begin
      if (rem >= PW'(n)) begin
        rem = rem - PW'(n);
        prow = prow + SW'(1);
      end
    end
    pcol = SW'(rem);
  end

  assign chain_valid[0] = feed_valid;
  assign chain_data[0] = feed_data;
  assign chain_k[0] = feed_k;

  for (genvar c = 0; c < MAX_SIZE; c++) begin : g_cell
    msp_mac_cell #(.MAX_SIZE(MAX_SIZE)) u_cell (
      .clk(clk), .rst(rst), .clear(clear),
      .load_en(load_b && (pcol == SW'(c))), .load_idx(KW'(prow)),
      .load_data(element_value),
      .a_valid_in(chain_valid[c]), .a_in(chain_data[c]), .a_k_in(chain_k[c]),
      .a_valid_out(chain_valid[c+1]), .a_out(chain_data[c+1]),
      .a_k_out(chain_k[c+1]), .acc(cell_acc[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      size_reg <= msp_pkg::SizeReset;
      pos <= '0;
      i <= '0;
      j <= '0;
      k <= '0;
      feed_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      feed_valid <= (state == ST_FEED);
      if (load_b || emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (cfg_fire) begin
            size_reg <= cfg_data;
            pos <= '0;
          end else if (load_a) begin
            pos <= pos + PW'(1);
          end else if (load_b) begin
            if (p == nn - PW'(1)) begin
              pos <= '0;
              i <= '0;
              j <= '0;
              k <= '0;
              state <= ST_FEED;
            end else begin
              pos <= pos + PW'(1);
            end
          end
        end
        ST_FEED: begin
          if (k == n_last) begin
            k <= '0;
            state <= ST_DRAIN;
          end else begin
            k <= k + SW'(1);
          end
        end
        ST_DRAIN: begin
          if (!chain_busy) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            if (j == n_last) begin
              j <= '0;
              if (i == n_last) begin
                i <= '0;
                state <= ST_LOAD;
              end else begin
                i <= i + SW'(1);
                state <= ST_FEED;
              end
            end else begin
              j <= j + SW'(1);
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_mem[IW'(pos)] <= element_value;
    end
    feed_data <= a_mem[IW'(a_addr)];
    feed_k <= KW'(k);
    if (load_b) begin
      result_value <= a_mem[IW'(p)] + element_value;
      result_kind <= msp_pkg::KindSum;
      result_row <= msp_pkg::IdxW'(prow);
      result_col <= msp_pkg::IdxW'(pcol);
      last_result <= 1'b0;
    end else if (emit_fire) begin
      result_value <= cell_acc[KW'(j)];
      result_kind <= msp_pkg::KindProd;
      result_row <= msp_pkg::IdxW'(i);
      result_col <= msp_pkg::IdxW'(j);
      last_result <= (i == n_last) && (j == n_last);
    end
  end

endmodule

[rtl/msp_mac_cell.sv]
// One cell of the product chain: holds one column of B, takes a row of A
// from its left neighbor one element a cycle and passes it on.
module msp_mac_cell #(
  parameter int MAX_SIZE = msp_pkg::MaxSize
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       load_en,
  input  logic [KW-1:0]              load_idx,
  input  logic [msp_pkg::DataW-1:0]  load_data,
  input  logic                       a_valid_in,
  input  logic [msp_pkg::DataW-1:0]  a_in,
  input  logic [KW-1:0]              a_k_in,
  output logic                       a_valid_out,
  output logic [msp_pkg::DataW-1:0]  a_out,
  output logic [KW-1:0]              a_k_out,
  output logic [msp_pkg::DataW-1:0]  acc
);

  localparam int KW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  logic [msp_pkg::DataW-1:0] col_b [MAX_SIZE];
  logic [msp_pkg::DataW-1:0] prod;

  // The A element travels with its k, which picks the matching B element.
  assign prod = a_in * col_b[a_k_in];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid_out <= 1'b0;
    end else begin
      a_valid_out <= a_valid_in;
    end
    a_out <= a_in;
    a_k_out <= a_k_in;
    if (clear) begin
      acc <= '0;
    end else if (a_valid_in) begin
      acc <= acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      col_b[load_idx] <= load_data;
    end
  end

endmodule
